// File: hdl/wall_majority_smoothing_top_defines.svh
// Assertion macros for the wall majority smoothing top level.
`ifndef WALL_MAJORITY_SMOOTHING_TOP_DEFINES_SVH
`define WALL_MAJORITY_SMOOTHING_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/wms_pkg.sv
// Shared constants, types and functions of the wall majority smoothing block.
package wms_pkg;

	localparam int MAX_COLS = 256;
	localparam int MAX_ROWS = 256;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int DIM_W = 9;
	localparam int TILE_W = 8;
	localparam int IDX_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = DIM_W;
	localparam int WALL_THRESHOLD = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_VALUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_VALUE = 3'd4;

	localparam logic [DIM_W-1:0] RST_MAP_ROWS = 9'd64;
	localparam logic [DIM_W-1:0] RST_MAP_COLS = 9'd64;
	localparam logic [TILE_W-1:0] RST_WALL_MAX = 8'd0;
	localparam logic [TILE_W-1:0] RST_WALL_VALUE = 8'd0;
	localparam logic [TILE_W-1:0] RST_FLOOR_VALUE = 8'd1;

	localparam logic [COL_W-1:0] COL_ONE = 1;
	localparam logic [COL_W-1:0] COL_TWO = 2;
	localparam logic [ROW_W-1:0] ROW_ONE = 1;

	// Job slots of one item, served lowest first.
	localparam int N_JOBS = 5;
	localparam int JOB_UP0 = 0;
	localparam int JOB_UP1 = 1;
	localparam int JOB_LO0 = 2;
	localparam int JOB_LO1 = 3;
	localparam int JOB_LO2 = 4;

	typedef logic [TILE_W-1:0] tile_t;
	typedef logic [N_JOBS-1:0] job_mask_t;

	// Window around the item in the input register. Index 0 of cur and upd_up is
	// column k-2, index 2 is column k; index 0 of orig_up is k-1, index 1 is k.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last_col;
		tile_t [2:0]      cur;
		tile_t [1:0]      orig_up;
		tile_t [2:0]      upd_up;
	} win_t;

	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] col;
		tile_t            value;
	} upd_wr_t;

	typedef struct packed {
		tile_t            tile;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             done;
	} result_t;

	typedef struct packed {
		tile_t wall_max;
		tile_t wall_value;
		tile_t floor_value;
	} rule_cfg_t;

	function automatic logic [ROW_W-1:0] last_row_of(input logic [DIM_W-1:0] v);
		logic [ROW_W-1:0] r;
		if (v < DIM_W'(3)) r = ROW_W'(2);
		else if (int'(v) > MAX_ROWS) r = ROW_W'(MAX_ROWS - 1);
		else r = ROW_W'(v - 1'b1);
		return r;
	endfunction

	function automatic logic [COL_W-1:0] last_col_of(input logic [DIM_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v < DIM_W'(3)) r = COL_W'(2);
		else if (int'(v) > MAX_COLS) r = COL_W'(MAX_COLS - 1);
		else r = COL_W'(v - 1'b1);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] row_idx(input logic [ROW_W-1:0] v);
		return IDX_W'(v);
	endfunction

	function automatic logic [IDX_W-1:0] col_idx(input logic [COL_W-1:0] v);
		return IDX_W'(v);
	endfunction

	// Majority rule over the eight neighbour wall flags.
	function automatic tile_t apply_rule(input logic [7:0] walls, input tile_t center,
		input rule_cfg_t cfg);
		logic [3:0] n;
		tile_t r;
		n = 4'($countones(walls));
		if (n < 4'(WALL_THRESHOLD)) r = cfg.floor_value;
		else if (n > 4'(WALL_THRESHOLD)) r = cfg.wall_value;
		else r = center;
		return r;
	endfunction

endpackage

// File: hdl/wms_window.sv
// Input register, scan position, line stores and column history of the window.
module wms_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  wms_pkg::tile_t              tile_in,
	input  logic                        restart,
	input  logic [wms_pkg::ROW_W-1:0]   rows_last,
	input  logic [wms_pkg::COL_W-1:0]   cols_last,
	input  wms_pkg::job_mask_t          fire_oh,
	input  wms_pkg::upd_wr_t            wr,
	output wms_pkg::win_t               win,
	output wms_pkg::job_mask_t          pend
);

	logic                      accept;
	logic                      at_last_col;
	logic                      at_last_row;
	logic [wms_pkg::ROW_W-1:0] row_q;
	logic [wms_pkg::COL_W-1:0] col_q;
	wms_pkg::job_mask_t        pend_s1;
	wms_pkg::job_mask_t        pend_next;
	wms_pkg::job_mask_t        jobs_new;
	logic [wms_pkg::ROW_W-1:0] row_s1;
	logic [wms_pkg::COL_W-1:0] col_s1;
	logic                      last_col_s1;
	wms_pkg::tile_t            cur_s1;
	wms_pkg::tile_t            cur_h1_q;
	wms_pkg::tile_t            cur_h2_q;
	wms_pkg::tile_t            orig_up_s1;
	wms_pkg::tile_t            orig_h1_q;
	wms_pkg::tile_t            upd_up_s1;
	wms_pkg::tile_t            upd_h1_q;
	wms_pkg::tile_t            upd_h2_q;
	wms_pkg::tile_t            orig_mem [wms_pkg::MAX_COLS];
	wms_pkg::tile_t            upd_mem [wms_pkg::MAX_COLS];

	// The register is free once its last job goes out in this cycle.
	assign pend_next = pend_s1 & ~fire_oh;
	assign in_ready = (pend_next == '0);
	assign accept = in_valid && in_ready;
	assign at_last_col = (col_q == cols_last);
	assign at_last_row = (row_q == rows_last);

	always_comb begin
		jobs_new = '0;
		jobs_new[wms_pkg::JOB_UP0] = (row_q != '0) && (col_q != '0);
		jobs_new[wms_pkg::JOB_UP1] = (row_q != '0) && at_last_col;
		jobs_new[wms_pkg::JOB_LO0] = at_last_row && (col_q >= wms_pkg::COL_TWO);
		jobs_new[wms_pkg::JOB_LO1] = at_last_row && at_last_col;
		jobs_new[wms_pkg::JOB_LO2] = at_last_row && at_last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pend_s1 <= '0;
		end else begin
			if (restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			pend_s1 <= accept ? jobs_new : pend_next;
		end
	end

	// Each item reads the row above before its own column is overwritten.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= row_q;
			col_s1 <= col_q;
			last_col_s1 <= at_last_col;
			cur_s1 <= tile_in;
			cur_h1_q <= cur_s1;
			cur_h2_q <= cur_h1_q;
			orig_up_s1 <= orig_mem[col_q];
			orig_mem[col_q] <= tile_in;
			orig_h1_q <= orig_up_s1;
			upd_up_s1 <= upd_mem[col_q];
			upd_h1_q <= upd_up_s1;
			upd_h2_q <= upd_h1_q;
		end
		if (wr.we) begin
			upd_mem[wr.col] <= wr.value;
		end
	end

	assign pend = pend_s1;

	always_comb begin
		win.row = row_s1;
		win.col = col_s1;
		win.last_col = last_col_s1;
		win.cur = {cur_s1, cur_h1_q, cur_h2_q};
		win.orig_up = {orig_up_s1, orig_h1_q};
		win.upd_up = {upd_up_s1, upd_h1_q, upd_h2_q};
	end

endmodule

// File: hdl/wms_calc.sv
// Job selection, neighbour window and majority rule; one smoothed tile per cycle while out_free is set.
module wms_calc (
	input  logic               clk,
	input  wms_pkg::win_t      win,
	input  wms_pkg::job_mask_t pend,
	input  logic               out_free,
	input  wms_pkg::rule_cfg_t cfg,
	output wms_pkg::job_mask_t fire_oh,
	output wms_pkg::result_t   res,
	output wms_pkg::upd_wr_t   wr
);

	wms_pkg::job_mask_t        sel_oh;
	logic                      fire;
	logic                      is_upper;
	wms_pkg::tile_t [3:0]      u_q;
	wms_pkg::tile_t            low_last_q;
	wms_pkg::tile_t            nw, n, ne, w, e, sw, s, se, ctr;
	wms_pkg::tile_t            new_tile;
	logic                      wall_above, wall_left, wall_right, wall_below;
	logic [7:0]                walls;
	logic [wms_pkg::ROW_W-1:0] res_row;
	logic [wms_pkg::COL_W-1:0] res_col;

	assign sel_oh = pend & (~pend + 1'b1);
	assign fire_oh = out_free ? sel_oh : '0;
	assign fire = |fire_oh;
	assign is_upper = sel_oh[wms_pkg::JOB_UP0] | sel_oh[wms_pkg::JOB_UP1];

	// u_q holds the latest smoothed tiles of the row above the input row,
	// newest first; low_last_q is the latest smoothed tile of the last row.
	always_comb begin
		nw = win.upd_up[0];
		n = win.upd_up[1];
		ne = win.upd_up[2];
		w = u_q[0];
		e = win.orig_up[1];
		ctr = win.orig_up[0];
		sw = win.cur[0];
		s = win.cur[1];
		se = win.cur[2];
		wall_above = (win.row == wms_pkg::ROW_ONE);
		wall_left = (win.col == wms_pkg::COL_ONE);
		wall_right = 1'b0;
		wall_below = 1'b0;
		res_row = win.row - wms_pkg::ROW_ONE;
		res_col = win.col - wms_pkg::COL_ONE;
		if (sel_oh[wms_pkg::JOB_UP1]) begin
			nw = win.upd_up[1];
			n = win.upd_up[2];
			ctr = win.orig_up[1];
			sw = win.cur[1];
			s = win.cur[2];
			wall_left = 1'b0;
			wall_right = 1'b1;
			res_col = win.col;
		end else if (!is_upper) begin
			// Last row: nothing below, left neighbour already smoothed.
			wall_above = 1'b0;
			wall_below = 1'b1;
			w = low_last_q;
			res_row = win.row;
			if (sel_oh[wms_pkg::JOB_LO0]) begin
				if (win.last_col) begin
					nw = u_q[3];
					n = u_q[2];
					ne = u_q[1];
				end else begin
					nw = u_q[2];
					n = u_q[1];
					ne = u_q[0];
				end
				ctr = win.cur[0];
				e = win.cur[1];
				wall_left = (win.col == wms_pkg::COL_TWO);
				res_col = win.col - wms_pkg::COL_TWO;
			end else if (sel_oh[wms_pkg::JOB_LO1]) begin
				nw = u_q[2];
				n = u_q[1];
				ne = u_q[0];
				ctr = win.cur[1];
				e = win.cur[2];
				wall_left = 1'b0;
				res_col = win.col - wms_pkg::COL_ONE;
			end else begin
				nw = u_q[1];
				n = u_q[0];
				ctr = win.cur[2];
				wall_left = 1'b0;
				wall_right = 1'b1;
				res_col = win.col;
			end
		end
	end

	always_comb begin
		walls[0] = wall_above | wall_left | (nw <= cfg.wall_max);
		walls[1] = wall_above | (n <= cfg.wall_max);
		walls[2] = wall_above | wall_right | (ne <= cfg.wall_max);
		walls[3] = wall_left | (w <= cfg.wall_max);
		walls[4] = wall_right | (e <= cfg.wall_max);
		walls[5] = wall_below | wall_left | (sw <= cfg.wall_max);
		walls[6] = wall_below | (s <= cfg.wall_max);
		walls[7] = wall_below | wall_right | (se <= cfg.wall_max);
	end

	assign new_tile = wms_pkg::apply_rule(walls, ctr, cfg);

	always_ff @(posedge clk) begin
		if (fire) begin
			if (is_upper) begin
				u_q <= {u_q[2:0], new_tile};
			end else begin
				low_last_q <= new_tile;
			end
		end
	end

	always_comb begin
		res.tile = new_tile;
		res.row = wms_pkg::row_idx(res_row);
		res.col = wms_pkg::col_idx(res_col);
		res.done = sel_oh[wms_pkg::JOB_LO2];
		wr.we = fire && is_upper;
		wr.col = res_col;
		wr.value = new_tile;
	end

endmodule

// File: hdl/wms_out_reg.sv
// Output register holding one smoothed item until the consumer takes it.
module wms_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wms_pkg::result_t din,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output wms_pkg::result_t dout
);

	logic             valid_q;
	wms_pkg::result_t data_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

	assign out_valid = valid_q;
	assign dout = data_q;

endmodule

// File: hdl/wall_majority_smoothing_top.sv
// Top level of the wall majority smoothing block: configuration registers and wiring.
// One in-place pass of the 4-5 cave smoothing rule over a map that streams in
// row by row. First-row tiles give no result; later tiles give one, none at
// column 0 and two at the last column, and in the last row two from the third
// column on and five for the final tile. A new tile is taken once the last has
// sent all its results through the single rule unit and the output register,
// which produce one result a cycle while the consumer takes them. Results
// carry their row and column and map_done marks the last tile of the map. Two
// line stores of one row each (original and smoothed ids) are read and written
// at most once a cycle. Writing map_rows or map_cols restarts the scan at the
// first tile; write configuration only while no results are outstanding.
`include "wall_majority_smoothing_top_defines.svh"

module wall_majority_smoothing_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [wms_pkg::TILE_W-1:0]      tile_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wms_pkg::TILE_W-1:0]      tile_out,
	output logic [wms_pkg::IDX_W-1:0]       row_index,
	output logic [wms_pkg::IDX_W-1:0]       col_index,
	output logic                            map_done,
	input  logic                            cfg_write_en,
	input  logic [wms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wms_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [wms_pkg::DIM_W-1:0]  map_rows_q;
	logic [wms_pkg::DIM_W-1:0]  map_cols_q;
	wms_pkg::tile_t             wall_max_q;
	wms_pkg::tile_t             wall_value_q;
	wms_pkg::tile_t             floor_value_q;
	logic                       restart;
	logic [wms_pkg::ROW_W-1:0]  rows_last;
	logic [wms_pkg::COL_W-1:0]  cols_last;
	wms_pkg::rule_cfg_t         rule_cfg;
	wms_pkg::win_t              win;
	wms_pkg::job_mask_t         pend;
	wms_pkg::job_mask_t         fire_oh;
	wms_pkg::result_t           res;
	wms_pkg::result_t           out_data;
	wms_pkg::upd_wr_t           wr;
	logic                       out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q <= wms_pkg::RST_MAP_ROWS;
			map_cols_q <= wms_pkg::RST_MAP_COLS;
			wall_max_q <= wms_pkg::RST_WALL_MAX;
			wall_value_q <= wms_pkg::RST_WALL_VALUE;
			floor_value_q <= wms_pkg::RST_FLOOR_VALUE;
		end else if (cfg_write_en) begin
			case (cfg_index)
				wms_pkg::REG_MAP_ROWS: map_rows_q <= cfg_data;
				wms_pkg::REG_MAP_COLS: map_cols_q <= cfg_data;
				wms_pkg::REG_WALL_MAX: wall_max_q <= cfg_data[wms_pkg::TILE_W-1:0];
				wms_pkg::REG_WALL_VALUE: wall_value_q <= cfg_data[wms_pkg::TILE_W-1:0];
				wms_pkg::REG_FLOOR_VALUE: floor_value_q <= cfg_data[wms_pkg::TILE_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_write_en &&
		(cfg_index == wms_pkg::REG_MAP_ROWS || cfg_index == wms_pkg::REG_MAP_COLS);
	assign rows_last = wms_pkg::last_row_of(map_rows_q);
	assign cols_last = wms_pkg::last_col_of(map_cols_q);

	always_comb begin
		rule_cfg.wall_max = wall_max_q;
		rule_cfg.wall_value = wall_value_q;
		rule_cfg.floor_value = floor_value_q;
	end

	wms_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.tile_in   (tile_in),
		.restart   (restart),
		.rows_last (rows_last),
		.cols_last (cols_last),
		.fire_oh   (fire_oh),
		.wr        (wr),
		.win       (win),
		.pend      (pend)
	);

	wms_calc u_calc (
		.clk      (clk),
		.win      (win),
		.pend     (pend),
		.out_free (out_free),
		.cfg      (rule_cfg),
		.fire_oh  (fire_oh),
		.res      (res),
		.wr       (wr)
	);

	wms_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (|fire_oh),
		.din       (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (out_data)
	);

	assign tile_out = out_data.tile;
	assign row_index = out_data.row;
	assign col_index = out_data.col;
	assign map_done = out_data.done;

	`WMS_ASSERT_NEXT(a_push_shows, |fire_oh, out_valid, "smoothed item lost after push")
	`WMS_ASSERT_NEXT(a_done_follows_last_job, fire_oh[wms_pkg::JOB_LO2], out_valid && map_done, "final tile not flagged")
	`WMS_ASSERT_NOW(a_upper_not_first_row, fire_oh[wms_pkg::JOB_UP0] || fire_oh[wms_pkg::JOB_UP1], win.row != '0, "upper row job issued on first input row")

endmodule

// File: dv/wall_majority_smoothing_top_tb.sv
// Self-checking testbench for the wall majority smoothing top level.
`timescale 1ns / 1ps

module wall_majority_smoothing_top_tb;
	import wms_pkg::*;

	localparam int RANDOM_ITEMS = 250;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 300;
	localparam int WIDE_PHASE = 2;
	localparam int TALL_PHASE = 5;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [TILE_W-1:0]     tile_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TILE_W-1:0]     tile_out;
	logic [IDX_W-1:0]      row_index;
	logic [IDX_W-1:0]      col_index;
	logic                  map_done;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wall_majority_smoothing_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tile_in     (tile_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tile_out    (tile_out),
		.row_index   (row_index),
		.col_index   (col_index),
		.map_done    (map_done),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Predictor state: whole frames of original and smoothed ids, scan position
	// of the next tile and a copy of the registers.
	tile_t           orig_map [MAX_ROWS][MAX_COLS];
	tile_t           smooth_map [MAX_ROWS][MAX_COLS];
	int              scan_row = 0;
	int              scan_col = 0;
	logic [DIM_W-1:0] rows_reg = RST_MAP_ROWS;
	logic [DIM_W-1:0] cols_reg = RST_MAP_COLS;
	tile_t           wall_limit = RST_WALL_MAX;
	tile_t           wall_id = RST_WALL_VALUE;
	tile_t           floor_id = RST_FLOOR_VALUE;

	result_t         smoothed_due [$];
	tile_t           pending_tiles [$];
	int              mismatch_count = 0;
	bit              in_took = 1'b0;
	bit              no_gaps = 1'b0;
	bit              long_hold_req = 1'b0;
	int              send_gap = 0;
	int              hold_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v < DIM_W'(3))
			return 3;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic tile_t smooth_tile_at(input int r, input int c, input int rows,
		input int cols);
		int walls, nr, nc, dr, dc;
		tile_t v, res;
		walls = 0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				nr = r + dr;
				nc = c + dc;
				if (dr == 0 && dc == 0)
					continue;
				if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) begin
					walls++;
				end else begin
					// Tiles earlier in scan order are already smoothed.
					if (nr < r || (nr == r && nc < c))
						v = smooth_map[nr][nc];
					else
						v = orig_map[nr][nc];
					if (v <= wall_limit)
						walls++;
				end
			end
		end
		if (walls < WALL_THRESHOLD)
			res = floor_id;
		else if (walls > WALL_THRESHOLD)
			res = wall_id;
		else
			res = orig_map[r][c];
		smooth_map[r][c] = res;
		return res;
	endfunction

	function automatic void queue_smoothed(input int r, input int c, input int rows,
		input int cols);
		result_t res;
		res.tile = smooth_tile_at(r, c, rows, cols);
		res.row = IDX_W'(r);
		res.col = IDX_W'(c);
		res.done = (r == rows - 1 && c == cols - 1);
		smoothed_due.push_back(res);
	endfunction

	function automatic void smooth_step(input tile_t t);
		int rows, cols, r, k;
		rows = eff_dim(rows_reg, MAX_ROWS);
		cols = eff_dim(cols_reg, MAX_COLS);
		if (scan_row >= rows || scan_col >= cols) begin
			scan_row = 0;
			scan_col = 0;
		end
		r = scan_row;
		k = scan_col;
		orig_map[r][k] = t;
		if (r >= 1) begin
			if (k >= 1)
				queue_smoothed(r - 1, k - 1, rows, cols);
			if (k == cols - 1)
				queue_smoothed(r - 1, k, rows, cols);
		end
		if (r == rows - 1) begin
			if (k >= 2 && k < cols - 1) begin
				queue_smoothed(r, k - 2, rows, cols);
			end else if (k == cols - 1) begin
				queue_smoothed(r, cols - 3, rows, cols);
				queue_smoothed(r, cols - 2, rows, cols);
				queue_smoothed(r, cols - 1, rows, cols);
			end
		end
		scan_col++;
		if (scan_col >= cols) begin
			scan_col = 0;
			scan_row++;
			if (scan_row >= rows)
				scan_row = 0;
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_MAP_ROWS: begin
				rows_reg = value;
				scan_row = 0;
				scan_col = 0;
			end
			REG_MAP_COLS: begin
				cols_reg = value;
				scan_row = 0;
				scan_col = 0;
			end
			REG_WALL_MAX: wall_limit = tile_t'(value);
			REG_WALL_VALUE: wall_id = tile_t'(value);
			REG_FLOOR_VALUE: floor_id = tile_t'(value);
			default: ;
		endcase
	endfunction

	function automatic int idle_len();
		int pick;
		if (no_gaps)
			return 0;
		pick = $urandom_range(99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(3, 1);
		if (pick < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 15);
	endfunction

	// Tiles are split between walls and floor under the current threshold.
	function automatic tile_t pick_tile();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2, 3: return tile_t'($urandom_range(int'(wall_limit), 0));
			default: begin
				if (wall_limit == '1)
					return '1;
				return tile_t'($urandom_range((1 << TILE_W) - 1, int'(wall_limit) + 1));
			end
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
		case ($urandom_range(4))
			0: return '0;
			1: return CFG_DATA_W'((1 << TILE_W) - 1);
			2: return '1;
			default: return CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		if ($urandom_range(4) == 0)
			return CFG_DATA_W'($urandom_range(2));
		return CFG_DATA_W'($urandom_range(8, 3));
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Sampling side: register writes, accepted tiles and accepted results.
	always @(posedge clk) begin
		result_t want;
		in_took = in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (smoothed_due.size() == 0) begin
					$display("%0t ns: result with none expected, tile %0d row %0d col %0d",
						$time, tile_out, row_index, col_index);
					mismatch_count++;
				end else begin
					want = smoothed_due.pop_front();
					check_field("tile_out", want.tile, tile_out);
					check_field("row_index", want.row, row_index);
					check_field("col_index", want.col, col_index);
					check_field("map_done", 8'(want.done), 8'(map_done));
				end
			end
			if (cfg_write_en)
				apply_reg(cfg_index, cfg_data);
			if (in_took)
				smooth_step(tile_in);
		end
	end

	// Tile sender.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_tiles.size() != 0) begin
				tile_in <= pending_tiles.pop_front();
				in_valid <= 1'b1;
				send_gap = idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with an occasional long hold-off on request.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			hold_left = idle_len();
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Waits until every tile is taken and every result has arrived, then lets
	// the block settle, since first-row tiles give no result of their own.
	task automatic drain();
		while (pending_tiles.size() != 0 || in_valid)
			@(posedge clk);
		@(negedge clk);
		while (smoothed_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic offer_random(input int count);
		@(posedge clk);
		repeat (count) pending_tiles.push_back(pick_tile());
	endtask

	initial begin
		int idx, rows, cols, count, random_sent, phase;
		bit restart;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: the first row and a few tiles of the second.
		offer_random(MAX_COLS / 4 + 6);
		drain();

		// Dimensions below range, a bit above the tile width set on the wall id, unused indexes.
		write_reg(REG_MAP_ROWS, '0);
		write_reg(REG_MAP_COLS, CFG_DATA_W'(2));
		write_reg(REG_WALL_MAX, '0);
		write_reg(REG_WALL_VALUE, CFG_DATA_W'(9'h1AA));
		write_reg(REG_FLOOR_VALUE, CFG_DATA_W'(9'h055));
		for (idx = int'(REG_FLOOR_VALUE) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), pick_reg_value());
		end_writes();
		@(posedge clk);
		for (idx = 0; idx < 9; idx++)
			pending_tiles.push_back((idx % 2 == 0) ? tile_t'('0) : tile_t'('1));
		drain();

		// Everything counts as wall; the scan has wrapped to a fresh map.
		write_reg(REG_WALL_MAX, CFG_DATA_W'((1 << TILE_W) - 1));
		write_reg(REG_WALL_VALUE, CFG_DATA_W'((1 << TILE_W) - 1));
		write_reg(REG_FLOOR_VALUE, '0);
		end_writes();
		@(posedge clk);
		for (idx = 0; idx < 9; idx++)
			pending_tiles.push_back((idx % 3 == 0) ? tile_t'('1) : tile_t'('0));
		drain();

		// Threshold changed part way through a map.
		offer_random(5);
		drain();
		write_reg(REG_WALL_MAX, CFG_DATA_W'(128));
		end_writes();
		offer_random(4);
		drain();

		// A dimension write abandons a half-streamed map.
		offer_random(4);
		drain();
		write_reg(REG_MAP_COLS, CFG_DATA_W'(3));
		end_writes();

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS || phase <= TALL_PHASE) begin
			no_gaps = ($urandom_range(3) == 0);
			if (phase == WIDE_PHASE) begin
				write_reg(REG_MAP_ROWS, CFG_DATA_W'(3));
				write_reg(REG_MAP_COLS, '1);
				end_writes();
				offer_random(3 * MAX_COLS);
			end else if (phase == TALL_PHASE) begin
				write_reg(REG_MAP_ROWS, CFG_DATA_W'(MAX_ROWS));
				write_reg(REG_MAP_COLS, '0);
				end_writes();
				offer_random(3 * MAX_ROWS);
				// The receiver backs off while tiles keep coming.
				long_hold_req = 1'b1;
			end else begin
				restart = ($urandom_range(2) != 0);
				if (restart) begin
					if ($urandom_range(3) != 0)
						write_reg(REG_MAP_ROWS, pick_dim());
					if ($urandom_range(3) != 0 || cfg_index != REG_MAP_ROWS)
						write_reg(REG_MAP_COLS, pick_dim());
				end
				if ($urandom_range(1) == 0)
					write_reg(REG_WALL_MAX, pick_reg_value());
				if ($urandom_range(1) == 0)
					write_reg(REG_WALL_VALUE, pick_reg_value());
				if ($urandom_range(1) == 0)
					write_reg(REG_FLOOR_VALUE, pick_reg_value());
				end_writes();
				rows = eff_dim(rows_reg, MAX_ROWS);
				cols = eff_dim(cols_reg, MAX_COLS);
				if (!restart)
					count = $urandom_range(rows * cols, 1);
				else if ($urandom_range(3) == 0)
					count = $urandom_range(rows * cols - 1, 1);
				else if ($urandom_range(2) == 0)
					count = rows * cols + $urandom_range(rows * cols - 1, 1);
				else
					count = rows * cols;
				offer_random(count);
				random_sent += count;
			end
			drain();
			phase++;
		end

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
